// File: hw/rtl/psu_pkg.sv
// Shared constants, filter type codes and neighbor struct for the PNG scanline unfilter.
`timescale 1ns / 1ps

package psu_pkg;

   localparam int ROW_MAX   = 8192;
   localparam int MAX_BPP   = 8;
   localparam int COL_W     = $clog2(ROW_MAX);
   localparam int RB_W      = COL_W + 1;
   localparam int BPP_W     = 4;
   localparam int BPP_IDX_W = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
   localparam int CSR_W     = RB_W;

   // register indexes on the configuration port
   localparam logic CSR_BPP      = 1'b0;
   localparam logic CSR_ROW_BYTES = 1'b1;

   // filter type codes
   localparam logic [2:0] FT_NONE    = 3'd0;
   localparam logic [2:0] FT_SUB     = 3'd1;
   localparam logic [2:0] FT_UP      = 3'd2;
   localparam logic [2:0] FT_AVERAGE = 3'd3;
   localparam logic [2:0] FT_PAETH   = 3'd4;

   // neighbors of the byte being rebuilt: left, above, upper left
   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
   } nbr_type;

endpackage

// File: hw/rtl/psu_predictor.sv
// Filter predictor: selects None, Sub, Up, Average or Paeth prediction from the neighbors.
`timescale 1ns / 1ps

module psu_predictor (
   input  logic [2:0]        filter_type,
   input  psu_pkg::nbr_type  nbr,
   output logic [7:0]        pred,
   output logic              bad
);
   import psu_pkg::*;

   logic [8:0]        avg_sum;
   logic signed [9:0] p_s;
   logic signed [9:0] da_s;
   logic signed [9:0] db_s;
   logic signed [9:0] dc_s;
   logic [9:0]        da;
   logic [9:0]        db;
   logic [9:0]        dc;
   logic [7:0]        paeth;

   assign avg_sum = {1'b0, nbr.a} + {1'b0, nbr.b};

   // p = a + b - c, then distances from p to each neighbor
   assign p_s  = $signed({2'b00, nbr.a}) + $signed({2'b00, nbr.b}) - $signed({2'b00, nbr.c});
   assign da_s = p_s - $signed({2'b00, nbr.a});
   assign db_s = p_s - $signed({2'b00, nbr.b});
   assign dc_s = p_s - $signed({2'b00, nbr.c});
   assign da   = da_s[9] ? 10'(-da_s) : 10'(da_s);
   assign db   = db_s[9] ? 10'(-db_s) : 10'(db_s);
   assign dc   = dc_s[9] ? 10'(-dc_s) : 10'(dc_s);

   always_comb begin
      if (da <= db && da <= dc) begin
         paeth = nbr.a;
      end else if (db <= dc) begin
         paeth = nbr.b;
      end else begin
         paeth = nbr.c;
      end
   end

   always_comb begin
      bad = 1'b0;
      case (filter_type)
         FT_NONE:    pred = 8'd0;
         FT_SUB:     pred = nbr.a;
         FT_UP:      pred = nbr.b;
         FT_AVERAGE: pred = avg_sum[8:1];
         FT_PAETH:   pred = paeth;
         default: begin
            pred = 8'd0;
            bad  = 1'b1;
         end
      endcase
   end

endmodule

// File: hw/rtl/png_scanline_unfilter_top.sv
// Top level of the PNG scanline unfilter: input stage, line store, histories, result register.
`timescale 1ns / 1ps

// PNG scanline reconstruction, one filtered byte per transfer.
// Input channel (req_*): filtered byte, the row's filter type and a new_image
// flag on the first byte of an image. Result channel (rsp_*): rebuilt byte, a
// row_end flag on the last byte of a scanline and bad_filter for unknown types,
// in which case the byte passes through unchanged.
// Configuration (csr_*): bytes_per_pixel (index 0) and row_bytes (index 1),
// to be written by the user only while no transfer is in flight; the block does not enforce it.
// An accepted byte passes two registers (input stage, result register) to rsp_*.
// Throughput: one byte per cycle while the receiver is ready. The line store has one write and
// one read port and is read one column ahead, so the byte above is ready when
// its column arrives.
// A stalled receiver holds the result register; the input stage still takes
// one more byte, then req_ready drops until the result is taken.
// Reset clears the pipeline, the column count and the histories and marks the
// next row as the first of an image. The line store is not cleared; it is
// always written before it is read within an image.
module png_scanline_unfilter_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_filtered_byte,
   input  logic [2:0]                req_filter_type,
   input  logic                      req_new_image,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_pixel_byte,
   output logic                      rsp_row_end,
   output logic                      rsp_bad_filter,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [psu_pkg::CSR_W-1:0] csr_wr_data
);
   import psu_pkg::*;

   // configuration
   logic [BPP_W-1:0]     bpp_ff;
   logic [RB_W-1:0]      rb_ff;
   logic [BPP_W-1:0]     bpp_eff;
   logic [RB_W-1:0]      rb_eff;
   logic [BPP_IDX_W-1:0] bpp_idx;

   // input stage
   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic [2:0] s1_type_ff;
   logic       s1_new_ff;

   // row position
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [COL_W-1:0] col_eff;
   logic [COL_W-1:0] col_cur;
   logic [COL_W-1:0] col_next;
   logic             first_row_ff;
   logic             first_row_in;
   logic             first_cur;
   logic             last_col;

   // line store
   logic [7:0]       line_mem [ROW_MAX];
   logic [COL_W-1:0] rd_addr;
   logic [7:0]       rd_data_ff;
   logic             byp_ff;
   logic [7:0]       byp_data_ff;
   logic [7:0]       above;

   // histories of the current row and the row above; entry j is j+1 places back
   logic [7:0] left_hist_ff [MAX_BPP];
   logic [7:0] ul_hist_ff   [MAX_BPP];

   // datapath
   logic       fire;
   nbr_type    nbr;
   logic [7:0] pred;
   logic       bad;
   logic [7:0] res;

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_end_ff;
   logic       rsp_bad_ff;

   // clamp register values to their legal ranges
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(MAX_BPP)) begin
         bpp_eff = BPP_W'(MAX_BPP);
      end else begin
         bpp_eff = bpp_ff;
      end
      if (rb_ff == '0) begin
         rb_eff = RB_W'(1);
      end else if (rb_ff > RB_W'(ROW_MAX)) begin
         rb_eff = RB_W'(ROW_MAX);
      end else begin
         rb_eff = rb_ff;
      end
   end
   assign bpp_idx = BPP_IDX_W'(bpp_eff - BPP_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff <= BPP_W'(1);
         rb_ff  <= RB_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BPP:       bpp_ff <= csr_wr_data[BPP_W-1:0];
            CSR_ROW_BYTES: rb_ff  <= csr_wr_data[RB_W-1:0];
            default:       ;
         endcase
      end
   end

   // process the staged byte when the result register is free or drains now
   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;
   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_filtered_byte;
         s1_type_ff <= req_filter_type;
         s1_new_ff  <= req_new_image;
      end
   end

   // column of the staged byte: restart on a new image, wrap if the row shrank
   assign col_eff   = ({1'b0, col_ff} >= rb_eff) ? '0 : col_ff;
   assign col_cur   = s1_new_ff ? '0 : col_eff;
   assign first_cur = s1_new_ff || first_row_ff;
   assign last_col  = ({1'b0, col_cur} == (rb_eff - RB_W'(1)));
   assign col_next  = last_col ? '0 : col_cur + COL_W'(1);

   assign col_in       = fire ? col_next : col_ff;
   assign first_row_in = fire ? (first_cur && !last_col) : first_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

   // read one column ahead; forward the written byte on an address match
   assign rd_addr = fire ? col_next : col_eff;

   always_ff @(posedge clock) begin
      if (fire) begin
         line_mem[col_cur] <= res;
      end
      rd_data_ff  <= line_mem[rd_addr];
      byp_ff      <= fire && (col_cur == rd_addr);
      byp_data_ff <= res;
   end

   assign above = byp_ff ? byp_data_ff : rd_data_ff;

   // neighbors: zero before the row start and above the first row
   always_comb begin
      nbr.b = first_cur ? 8'd0 : above;
      if (col_cur >= COL_W'(bpp_eff)) begin
         nbr.a = left_hist_ff[bpp_idx];
         nbr.c = first_cur ? 8'd0 : ul_hist_ff[bpp_idx];
      end else begin
         nbr.a = 8'd0;
         nbr.c = 8'd0;
      end
   end

   psu_predictor u_predictor (
      .filter_type (s1_type_ff),
      .nbr         (nbr),
      .pred        (pred),
      .bad         (bad)
   );

   assign res = s1_byte_ff + pred;

   // advance both histories by one byte per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_BPP; j++) begin
            left_hist_ff[j] <= 8'd0;
            ul_hist_ff[j]   <= 8'd0;
         end
      end else if (fire) begin
         for (int j = MAX_BPP - 1; j > 0; j--) begin
            left_hist_ff[j] <= left_hist_ff[j-1];
            ul_hist_ff[j]   <= ul_hist_ff[j-1];
         end
         left_hist_ff[0] <= res;
         ul_hist_ff[0]   <= nbr.b;
      end
   end

   // result register: load on fire, drop valid once the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_byte_ff <= res;
         rsp_end_ff  <= last_col;
         rsp_bad_ff  <= bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_byte_ff;
   assign rsp_row_end    = rsp_end_ff;
   assign rsp_bad_filter = rsp_bad_ff;

endmodule
